// ===== hw/rtl/scmm_pkg.sv =====
// Shared types, codes and saturating helpers for the spectral cube moment map unit.
// Used by spectral_cube_moment_map_unit and its port checker; depends on nothing else.
package scmm_pkg;

  // Request kinds carried in the input beat.
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ACCUM = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Accumulation passes.
  localparam logic [1:0] PASS_INT  = 2'd0;
  localparam logic [1:0] PASS_MEAN = 2'd1;
  localparam logic [1:0] PASS_DISP = 2'd2;

  // Moment selector codes.
  localparam logic [2:0] ORD_INT  = 3'd0;
  localparam logic [2:0] ORD_MEAN = 3'd1;
  localparam logic [2:0] ORD_DISP = 3'd2;
  localparam logic [2:0] ORD_MAX  = 3'd3;
  localparam logic [2:0] ORD_MIN  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ORDER  = 2'd0;
  localparam logic [1:0] CFG_STEP   = 2'd1;
  localparam logic [1:0] CFG_ORIGIN = 2'd2;

  // Entry flag bits.
  localparam int FLAG_INT  = 0;
  localparam int FLAG_MEAN = 1;
  localparam int FLAG_DISP = 2;
  localparam int FLAG_EXT  = 3;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_MUL_W,
    ST_CAPW,
    ST_MUL_V,
    ST_CAPV,
    ST_SUBD,
    ST_LDP,
    ST_MUL_P,
    ST_DIV_CHK,
    ST_DIV,
    ST_QDONE,
    ST_LDQ,
    ST_MUL_Q,
    ST_SHQ,
    ST_WRITE
  } state_t;

  // One pixel entry of the moment store.
  typedef struct packed {
    logic [3:0]  flags;
    logic [31:0] extreme;
    logic [63:0] disp;
    logic [63:0] mean;
    logic [63:0] integ;
  } entry_t;

  // Magnitude of a signed 64-bit value, as unsigned.
  function automatic logic [63:0] mag64(input logic [63:0] x);
    mag64 = x[63] ? (~x + 64'd1) : x;
  endfunction

  // Signed value from sign and magnitude, saturated to signed 64 bits.
  function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m);
    if (!neg) begin
      from_mag = m[63] ? S64_MAX : m;
    end else begin
      from_mag = m[63] ? S64_MIN : (~m + 64'd1);
    end
  endfunction

  // Saturating signed add.
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? S64_MIN : S64_MAX;
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  // Saturating signed subtract.
  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      sat_sub = s[64] ? S64_MIN : S64_MAX;
    end else begin
      sat_sub = s[63:0];
    end
  endfunction

endpackage

// ===== hw/rtl/spectral_cube_moment_map_unit.sv =====
// Spectral cube moment map: request decode, sequencer, shared multiply/divide unit, pixel store.
// Depends on scmm_pkg.

// Each beat is a clear, an accumulate or a read request for one map pixel. A clear is written to
// the store as the beat is taken, a read waits for the result slot, and ignored requests leave
// the block idle. Accumulates run through a single 32x32 multiplier, used four times per 64x64
// product, and a one-bit-per-cycle restoring divider. Pass 0 needs no divide, a later-pass sample
// on a pixel with no nonzero integral is skipped, and the divider is bypassed when the quotient
// saturates. The input is not ready while an item is in work. The pixel store is one read and
// one write port memory; it is not cleared by reset, so each pixel must get a clear request
// before use. A finished read result waits in an output register while the next beat is taken.
module spectral_cube_moment_map_unit
  import scmm_pkg::*;
#(
  parameter int PIXELS   = 4096,
  parameter int CHANNELS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: pixel_index[11:0], channel_index[21:12], sample_value[53:22], zero pad[55:54]
  input  logic [55:0] in_tdata,
  // tuser: req_type[1:0], pass_number[3:2], sample_finite[4]
  input  logic [4:0]  in_tuser,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: map_value[63:0]
  output logic [63:0] out_tdata,
  // tuser: map_valid[0]
  output logic [0:0]  out_tuser,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int PIX_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [31:0] PIX_LIM = 32'(PIXELS);
  localparam logic [31:0] CH_LIM  = 32'(CHANNELS);
  localparam logic [5:0]  MUL_LAST = 6'd4;
  localparam logic [5:0]  DIV_LAST = 6'd63;

  // Beat fields.
  logic [11:0] in_pixel;
  logic [9:0]  in_channel;
  logic [31:0] in_sample;
  logic [1:0]  in_req;
  logic [1:0]  in_pass;
  logic        in_finite;
  logic        in_fire;
  logic        in_pix_ok;
  logic        in_acc_ok;
  logic [31:0] in_pix_ext;
  logic [31:0] in_smag;

  assign in_pixel   = in_tdata[11:0];
  assign in_channel = in_tdata[21:12];
  assign in_sample  = in_tdata[53:22];
  assign in_req     = in_tuser[1:0];
  assign in_pass    = in_tuser[3:2];
  assign in_finite  = in_tuser[4];
  assign in_fire    = in_tvalid & in_tready;
  assign in_pix_ext = {20'd0, in_pixel};
  assign in_pix_ok  = in_pix_ext < PIX_LIM;
  assign in_acc_ok  = in_pix_ok && ({22'd0, in_channel} < CH_LIM) &&
                      (in_pass != 2'd3) && in_finite;
  assign in_smag    = in_sample[31] ? (~in_sample + 32'd1) : in_sample;

  // Control registers.
  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  order_r;
  logic [31:0] step_r;
  logic [31:0] origin_r;

  // Payload registers.
  logic [1:0]        pass_r, pass_nxt;
  logic [PIX_AW-1:0] pix_addr_r, pix_addr_nxt;
  logic              pix_ok_r, pix_ok_nxt;
  logic [9:0]        ch_r, ch_nxt;
  logic [31:0]       s_r, s_nxt;
  logic [63:0]       op_a_r, op_a_nxt;
  logic [63:0]       op_b_r, op_b_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic [127:0]      acc_r, acc_nxt;
  logic [63:0]       w_r, w_nxt;
  logic [63:0]       x_r, x_nxt;
  logic [63:0]       q_r, q_nxt;
  logic [63:0]       dmag_r, dmag_nxt;
  logic [63:0]       out_value_r, out_value_nxt;
  logic              out_ok_r, out_ok_nxt;

  // Store and its ports.
  entry_t            mem [PIXELS];
  entry_t            rd_data_r;
  entry_t            wr_data;
  entry_t            wb_entry;
  logic              rd_en;
  logic              mem_we;
  logic [PIX_AW-1:0] wr_addr;
  logic              out_load;

  // Shared unit signals.
  logic        mul_state;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [1:0]  pp_idx;
  logic [127:0] pp_shifted;
  logic [64:0] div_shift;
  logic [64:0] div_diff;
  logic        div_ge;
  logic [63:0] div_rem;
  logic [63:0] v_val;
  logic [63:0] shq_mag;
  logic        mul_done;

  // Read result selection.
  logic [63:0] rd_value;
  logic        rd_ok;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= ORD_INT;
      step_r   <= 32'd65536;
      origin_r <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORDER:  order_r  <= cfg_wdata[2:0];
        CFG_STEP:   step_r   <= cfg_wdata;
        CFG_ORIGIN: origin_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Pixel store, one read and one write port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[in_pix_ext[PIX_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Shared multiplier operand halves and partial-product alignment.
  assign mul_state = (state_r == ST_MUL_W) || (state_r == ST_MUL_V) ||
                     (state_r == ST_MUL_P) || (state_r == ST_MUL_Q);
  assign mul_done  = cnt_r == MUL_LAST;
  assign mul_a     = cnt_r[1] ? op_a_r[63:32] : op_a_r[31:0];
  assign mul_b     = cnt_r[0] ? op_b_r[63:32] : op_b_r[31:0];
  assign pp_idx    = 2'(cnt_r - 6'd1);

  always_comb begin
    unique case (pp_idx)
      2'd0:    pp_shifted = {64'd0, prod_r};
      2'd3:    pp_shifted = {prod_r, 64'd0};
      default: pp_shifted = {32'd0, prod_r, 32'd0};
    endcase
  end

  // Restoring divider step: remainder in the upper half, dividend and quotient in the lower.
  assign div_shift = {acc_r[127:64], acc_r[63]};
  assign div_diff  = div_shift - {1'b0, dmag_r};
  assign div_ge    = div_shift >= {1'b0, dmag_r};
  assign div_rem   = div_ge ? div_diff[63:0] : div_shift[63:0];

  // Spectral coordinate of the channel, from step * channel in the accumulator.
  assign v_val   = {{32{origin_r[31]}}, origin_r} + acc_r[63:0];
  // Product shifted down by 32, saturated on overflow.
  assign shq_mag = (acc_r[127:96] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : acc_r[95:32];

  // Entry written back at the end of an accumulate.
  always_comb begin
    wb_entry = rd_data_r;
    unique case (pass_r)
      PASS_INT: begin
        wb_entry.integ = sat_add(rd_data_r.integ, w_r);
        if (!rd_data_r.flags[FLAG_EXT] ||
            ((order_r == ORD_MIN) ? ($signed(s_r) < $signed(rd_data_r.extreme))
                                  : ($signed(s_r) > $signed(rd_data_r.extreme)))) begin
          wb_entry.extreme = s_r;
        end
        wb_entry.flags[FLAG_INT] = 1'b1;
        wb_entry.flags[FLAG_EXT] = 1'b1;
      end
      PASS_MEAN: begin
        wb_entry.mean = sat_add(rd_data_r.mean, q_r);
        wb_entry.flags[FLAG_MEAN] = 1'b1;
      end
      PASS_DISP: begin
        wb_entry.disp = sat_add(rd_data_r.disp, q_r);
        wb_entry.flags[FLAG_DISP] = 1'b1;
      end
      default: ;
    endcase
  end

  // Moment selected for a read.
  always_comb begin
    rd_value = 64'd0;
    rd_ok    = 1'b0;
    unique case (order_r)
      ORD_INT: begin
        rd_ok    = rd_data_r.flags[FLAG_INT];
        rd_value = rd_data_r.integ;
      end
      ORD_MEAN: begin
        rd_ok    = rd_data_r.flags[FLAG_MEAN];
        rd_value = rd_data_r.mean;
      end
      ORD_DISP: begin
        rd_ok    = rd_data_r.flags[FLAG_DISP];
        rd_value = rd_data_r.disp;
      end
      ORD_MAX, ORD_MIN: begin
        rd_ok    = rd_data_r.flags[FLAG_EXT];
        rd_value = {{16{rd_data_r.extreme[31]}}, rd_data_r.extreme, 16'd0};
      end
      default: ;
    endcase
    rd_ok = rd_ok & pix_ok_r;
    if (!rd_ok) begin
      rd_value = 64'd0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_req == REQ_READ) begin
            state_nxt = ST_RESP;
          end else if (in_req == REQ_ACCUM && in_acc_ok) begin
            state_nxt = ST_MUL_W;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL_W: if (mul_done) state_nxt = ST_CAPW;
      ST_CAPW: begin
        priority if (pass_r == PASS_INT) begin
          state_nxt = ST_WRITE;
        end else if (rd_data_r.flags[FLAG_INT] && rd_data_r.integ != 64'd0) begin
          state_nxt = ST_MUL_V;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL_V: if (mul_done) state_nxt = ST_CAPV;
      ST_CAPV:  state_nxt = (pass_r == PASS_DISP) ? ST_SUBD : ST_LDP;
      ST_SUBD:  state_nxt = ST_LDP;
      ST_LDP:   state_nxt = ST_MUL_P;
      ST_MUL_P: if (mul_done) state_nxt = ST_DIV_CHK;
      ST_DIV_CHK: begin
        state_nxt = (acc_r[127:64] >= dmag_r) ? ST_QDONE : ST_DIV;
      end
      ST_DIV:   if (cnt_r == DIV_LAST) state_nxt = ST_QDONE;
      ST_QDONE: state_nxt = (pass_r == PASS_DISP) ? ST_LDQ : ST_WRITE;
      ST_LDQ:   state_nxt = ST_MUL_Q;
      ST_MUL_Q: if (mul_done) state_nxt = ST_SHQ;
      ST_SHQ:   state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    wr_addr   = pix_addr_r;
    wr_data   = wb_entry;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        rd_en     = in_fire && in_pix_ok &&
                    (in_req == REQ_READ || in_req == REQ_ACCUM);
        if (in_fire && in_req == REQ_CLEAR && in_pix_ok) begin
          mem_we  = 1'b1;
          wr_addr = in_pix_ext[PIX_AW-1:0];
          wr_data = '0;
        end
      end
      ST_RESP:  out_load = !out_valid_r || out_tready;
      ST_WRITE: mem_we   = 1'b1;
      default:  ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    cnt_nxt       = 6'd0;
    pass_nxt      = pass_r;
    pix_addr_nxt  = pix_addr_r;
    pix_ok_nxt    = pix_ok_r;
    ch_nxt        = ch_r;
    s_nxt         = s_r;
    op_a_nxt      = op_a_r;
    op_b_nxt      = op_b_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    w_nxt         = w_r;
    x_nxt         = x_r;
    q_nxt         = q_r;
    dmag_nxt      = dmag_r;
    out_value_nxt = out_value_r;
    out_ok_nxt    = out_ok_r;
    out_valid_nxt = out_valid_r & ~out_tready;

    // Latch the beat and set up the first product, |sample| * step.
    if (state_r == ST_IDLE && in_fire) begin
      pass_nxt     = in_pass;
      pix_addr_nxt = in_pix_ext[PIX_AW-1:0];
      pix_ok_nxt   = in_pix_ok;
      ch_nxt       = in_channel;
      s_nxt        = in_sample;
      op_a_nxt     = {32'd0, in_smag};
      op_b_nxt     = {32'd0, step_r};
    end

    // Shared multiplier: one 32x32 partial product per cycle, summed in the next cycle.
    if (mul_state) begin
      cnt_nxt  = mul_done ? 6'd0 : cnt_r + 6'd1;
      prod_nxt = mul_a * mul_b;
      acc_nxt  = (cnt_r == 6'd0) ? 128'd0 : acc_r + pp_shifted;
    end

    unique case (state_r)
      ST_RESP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_value;
          out_ok_nxt    = rd_ok;
        end
      end
      ST_CAPW: begin
        w_nxt    = s_r[31] ? (~acc_r[63:0] + 64'd1) : acc_r[63:0];
        dmag_nxt = mag64(rd_data_r.integ);
        op_a_nxt = {32'd0, step_r};
        op_b_nxt = {54'd0, ch_r};
      end
      ST_CAPV:  x_nxt = {v_val[47:0], 16'd0};
      ST_SUBD:  x_nxt = sat_sub(x_r, rd_data_r.mean);
      ST_LDP: begin
        op_a_nxt = mag64(w_r);
        op_b_nxt = mag64(x_r);
      end
      ST_DIV_CHK: begin
        // Quotient would not fit: force an all-ones magnitude.
        if (acc_r[127:64] >= dmag_r) begin
          acc_nxt[63:0] = 64'hFFFF_FFFF_FFFF_FFFF;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        acc_nxt = {div_rem, acc_r[62:0], div_ge};
      end
      ST_QDONE: begin
        q_nxt = from_mag(w_r[63] ^ x_r[63] ^ rd_data_r.integ[63], acc_r[63:0]);
      end
      ST_LDQ: begin
        op_a_nxt = mag64(q_r);
        op_b_nxt = mag64(x_r);
      end
      ST_SHQ:   q_nxt = from_mag(q_r[63] ^ x_r[63], shq_mag);
      default:  ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pass_r      <= pass_nxt;
    pix_addr_r  <= pix_addr_nxt;
    pix_ok_r    <= pix_ok_nxt;
    ch_r        <= ch_nxt;
    s_r         <= s_nxt;
    op_a_r      <= op_a_nxt;
    op_b_r      <= op_b_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    w_r         <= w_nxt;
    x_r         <= x_nxt;
    q_r         <= q_nxt;
    dmag_r      <= dmag_nxt;
    out_value_r <= out_value_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_ok_r;

endmodule

// ===== hw/rtl/scmm_checker.sv =====
// Port-level checks for spectral_cube_moment_map_unit, bound onto the top level.
// Depends on scmm_pkg for the request codes.
module scmm_checker
  import scmm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [4:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // An empty pixel reads as zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 64'd0)
    else $error("map_value nonzero with map_valid low");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  // A read keeps the input closed while its result is formed.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[1:0] == REQ_READ |=> !in_tready)
    else $error("input ready in the cycle after a read");

  // A new result appears only out of a busy cycle.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised while input was open");

endmodule

bind spectral_cube_moment_map_unit scmm_checker u_scmm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
